[design/tbp_pkg.sv]
// Shared types, register codes and helpers of the tile bitplane packer.
`timescale 1ns / 1ps
package tbp_pkg;

	localparam int COLOR_W   = 24;
	localparam int TILES_W   = 6;
	localparam int CFG_IDX_W = 2;
	localparam int ADDR_W    = 13;
	localparam int ROW_LO_W  = 3;
	localparam int TILE_W    = ADDR_W - ROW_LO_W;
	localparam int PIX_W     = TILES_W + 3;
	localparam int CMP_W     = 11;
	localparam int Q_DEPTH   = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASK_KEY     = 2'd0,
		REG_ZERO_COLOR   = 2'd1,
		REG_WIDTH_TILES  = 2'd2,
		REG_HEIGHT_TILES = 2'd3
	} cfg_reg_t;

	// Frame geometry and colors after reset values and clamping
	typedef struct packed {
		logic [COLOR_W-1:0] mask_key;
		logic [COLOR_W-1:0] zero_color;
		logic [TILES_W-1:0] width_tiles;
		logic [TILES_W-1:0] height_tiles;
	} cfg_t;

	// One packed byte pair waiting for its address
	typedef struct packed {
		logic [TILE_W-1:0]   tile_row;
		logic [TILE_W-1:0]   tile_col;
		logic [ROW_LO_W-1:0] row_lo;
		logic [7:0]          data_byte;
		logic [7:0]          mask_byte;
		logic                frame_last;
	} byte_item_t;

	// Zero reads as one tile, anything above the limit saturates
	function automatic logic [TILES_W-1:0] clamp_tiles(input logic [TILES_W-1:0] v,
			input int limit);
		logic [TILES_W-1:0] r;
		r = v;
		if (v == '0)
			r = TILES_W'(1);
		else if (int'(v) > limit)
			r = TILES_W'(limit);
		return r;
	endfunction

endpackage

[design/tbp_if.sv]
// Channel interfaces: pixel input, packed byte output, register writes.
`timescale 1ns / 1ps
interface tbp_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

interface tbp_byte_if;
	logic                      valid;
	logic                      ready;
	logic [tbp_pkg::ADDR_W-1:0] byte_address;
	logic [7:0]                data_byte;
	logic [7:0]                mask_byte;
	logic                      frame_last;

	modport source (output valid, byte_address, data_byte, mask_byte, frame_last,
		input ready);
	modport sink   (input valid, byte_address, data_byte, mask_byte, frame_last,
		output ready);
endinterface

interface tbp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tbp_pkg::CFG_IDX_W-1:0] index;
	logic [tbp_pkg::COLOR_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[design/tbp_front.sv]
// Front end: classifies pixels, tracks position and packs eight bits per byte.
`timescale 1ns / 1ps
module tbp_front #(
	parameter int COL_W = 8,
	parameter int ROW_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	tbp_pixel_if.sink           pixel,
	input  tbp_pkg::cfg_t       cfg,
	input  logic                q_full,
	output logic                q_push,
	output tbp_pkg::byte_item_t q_item
);
	import tbp_pkg::*;

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [6:0]         data_sh_q;
	logic [6:0]         mask_sh_q;
	logic [COLOR_W-1:0] pix;
	logic               mbit;
	logic               dbit;
	logic [PIX_W-1:0]   wpix;
	logic [PIX_W-1:0]   hpix;
	logic               accept;
	logic               group_end;
	logic               line_end;
	logic               frame_end;

	// Classify the pixel: mask color wins over data
	assign pix  = {pixel.red, pixel.green, pixel.blue};
	assign mbit = (pix == cfg.mask_key);
	assign dbit = !mbit && (pix != cfg.zero_color);

	// Frame size in pixels and position tests
	assign wpix      = {cfg.width_tiles, 3'b000};
	assign hpix      = {cfg.height_tiles, 3'b000};
	assign line_end  = CMP_W'(col_q) >= (CMP_W'(wpix) - CMP_W'(1));
	assign frame_end = line_end && (CMP_W'(row_q) >= (CMP_W'(hpix) - CMP_W'(1)));
	assign group_end = (col_q[2:0] == 3'b111);

	assign pixel.ready = !q_full;
	assign accept      = pixel.valid && pixel.ready;
	assign q_push      = accept && group_end;

	// Build the byte item from the gathered bits and the current position
	always_comb begin
		q_item.tile_row   = TILE_W'(row_q >> 3);
		q_item.tile_col   = TILE_W'(col_q >> 3);
		q_item.row_lo     = row_q[2:0];
		q_item.data_byte  = {data_sh_q, dbit};
		q_item.mask_byte  = {mask_sh_q, mbit};
		q_item.frame_last = frame_end;
	end

	// Advance position and shift in bits; clear at group and line ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			data_sh_q <= '0;
			mask_sh_q <= '0;
		end else if (accept) begin
			if (group_end || line_end) begin
				data_sh_q <= '0;
				mask_sh_q <= '0;
			end else begin
				data_sh_q <= {data_sh_q[5:0], dbit};
				mask_sh_q <= {mask_sh_q[5:0], mbit};
			end
			if (line_end) begin
				col_q <= '0;
				if (frame_end)
					row_q <= '0;
				else
					row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	a_line_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && line_end |=> col_q == '0 && data_sh_q == '0 && mask_sh_q == '0)
		else $error("column or shift state not cleared at line end");

endmodule

[design/tbp_queue.sv]
// Short queue of byte items between the front and back ends.
`timescale 1ns / 1ps
module tbp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tbp_pkg::byte_item_t push_item,
	output logic                full,
	input  logic                pop,
	output logic                nonempty,
	output tbp_pkg::byte_item_t pop_item
);
	import tbp_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	byte_item_t       store_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(Q_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_item = store_q[rd_ptr_q];

	// Write storage
	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_ptr_q] <= push_item;
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !nonempty))
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(Q_DEPTH))
		else $error("queue fill level out of range");

endmodule

[design/tbp_back.sv]
// Back end: forms the tile-order address and holds the result item.
`timescale 1ns / 1ps
module tbp_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [tbp_pkg::TILES_W-1:0] width_tiles,
	input  logic                      q_nonempty,
	input  tbp_pkg::byte_item_t       q_item,
	output logic                      q_pop,
	tbp_byte_if.source                tile_byte
);
	import tbp_pkg::*;

	localparam int PROD_W = TILE_W + TILES_W;

	logic              out_valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        data_q;
	logic [7:0]        mask_q;
	logic              last_q;
	logic [PROD_W-1:0] band_offset;
	logic [TILE_W-1:0] tile_index;
	logic              load;

	// Tile index = band * tiles per line + column tile, kept to the tile index width
	assign band_offset = PROD_W'(q_item.tile_row) * PROD_W'(width_tiles);
	assign tile_index  = band_offset[TILE_W-1:0] + q_item.tile_col;

	assign load  = q_nonempty && (!out_valid_q || tile_byte.ready);
	assign q_pop = load;

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (tile_byte.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_q <= {tile_index, q_item.row_lo};
			data_q <= q_item.data_byte;
			mask_q <= q_item.mask_byte;
			last_q <= q_item.frame_last;
		end
	end

	assign tile_byte.valid        = out_valid_q;
	assign tile_byte.byte_address = addr_q;
	assign tile_byte.data_byte    = data_q;
	assign tile_byte.mask_byte    = mask_q;
	assign tile_byte.frame_last   = last_q;

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !tile_byte.ready |=> out_valid_q && $stable(addr_q))
		else $error("result item lost while stalled");

endmodule

[design/tile_bitplane_packer_core.sv]
// Top level of the tile bitplane packer: registers, front, queue and back.
//
// Channel     Dir  Payload                                          Handshake
// pixel       in   red, green, blue                                 valid/ready
// tile_byte   out  byte_address, data_byte, mask_byte, frame_last   valid/ready
// cfg         in   index, data                                      valid/ready (always ready)
//
// One pixel per clock is accepted; every eighth pixel of a line gives one item.
// An item is written into the queue with its last pixel and then loaded into the
// output register; the front is limited only by the four-entry queue being full.
// Reset clears position, bits, queue and output valid; registers take their
// reset values (width 32 tiles, height 24 bands, colors zero).
// An output stall backs up through the queue to the pixel input.
`timescale 1ns / 1ps
module tile_bitplane_packer_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	tbp_pixel_if.sink  pixel,
	tbp_byte_if.source tile_byte,
	tbp_cfg_if.sink    cfg
);
	import tbp_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int W_LIM  = (MAX_WIDTH / 8 == 0) ? 1 : MAX_WIDTH / 8;
	localparam int H_LIM  = (MAX_HEIGHT / 8 == 0) ? 1 : MAX_HEIGHT / 8;

	logic [COLOR_W-1:0] mask_key_q;
	logic [COLOR_W-1:0] zero_color_q;
	logic [TILES_W-1:0] width_tiles_q;
	logic [TILES_W-1:0] height_tiles_q;
	cfg_t               cfg_eff;
	byte_item_t         push_item;
	byte_item_t         pop_item;
	logic               q_full;
	logic               q_push;
	logic               q_pop;
	logic               q_nonempty;

	assign cfg.ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_key_q     <= '0;
			zero_color_q   <= '0;
			width_tiles_q  <= TILES_W'(32);
			height_tiles_q <= TILES_W'(24);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_MASK_KEY:     mask_key_q     <= cfg.data;
				REG_ZERO_COLOR:   zero_color_q   <= cfg.data;
				REG_WIDTH_TILES:  width_tiles_q  <= cfg.data[TILES_W-1:0];
				REG_HEIGHT_TILES: height_tiles_q <= cfg.data[TILES_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp frame size to the supported range
	always_comb begin
		cfg_eff.mask_key     = mask_key_q;
		cfg_eff.zero_color   = zero_color_q;
		cfg_eff.width_tiles  = clamp_tiles(width_tiles_q, W_LIM);
		cfg_eff.height_tiles = clamp_tiles(height_tiles_q, H_LIM);
	end

	tbp_front #(
		.COL_W (COL_W),
		.ROW_W (ROW_W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.cfg    (cfg_eff),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (push_item)
	);

	tbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_item  (pop_item)
	);

	tbp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.width_tiles (cfg_eff.width_tiles),
		.q_nonempty  (q_nonempty),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.tile_byte   (tile_byte)
	);

endmodule
